// File: rtl/ova_pkg.sv
// Shared types and constants for the octant vector angle block.
`timescale 1ns / 1ps
`default_nettype none
package ova_pkg;

    localparam int DATA_W      = 16;
    localparam int MAG_W       = 16;
    localparam int QUO_W       = 6;
    localparam int DIV_STAGES  = QUO_W;
    localparam int ANGLE_W     = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Quadrant codes: bit 1 is dx negative, bit 0 is dy negative.
    localparam logic [1:0] QUAD_XP_YP = 2'd0;
    localparam logic [1:0] QUAD_XP_YN = 2'd1;
    localparam logic [1:0] QUAD_XN_YP = 2'd2;
    localparam logic [1:0] QUAD_XN_YN = 2'd3;

    localparam logic [ANGLE_W-1:0] ANG_UP    = 8'd0;
    localparam logic [ANGLE_W-1:0] ANG_RIGHT = 8'd64;
    localparam logic [ANGLE_W-1:0] ANG_DOWN  = 8'd128;
    localparam logic [ANGLE_W-1:0] ANG_LEFT  = 8'd192;
    // Slope substituted for the zero vector: all ones.
    localparam logic [ANGLE_W-1:0] SLOPE_ZERO_VEC = 8'hFF;

    typedef struct packed {
        logic [MAG_W-1:0] small_mag;
        logic [MAG_W-1:0] large_mag;
        logic [1:0]       quad;
        logic             hdom;
        logic             zero_vec;
    } item_t;

endpackage
`default_nettype wire

// File: rtl/octant_vector_angle.sv
// Top level: vector to 8-bit binary angle, classifier, queue and divider pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Converts a signed 16-bit vector (dx, dy) into an 8-bit binary angle: 0 is up
// (negative dy), 64 right, 128 down, 192 left. One vector beat is taken every
// cycle while the output is not stalled, and one angle beat comes out per vector,
// in order. Each beat passes through the classifier register, the 4-entry queue,
// the six stages of the restoring divider (one quotient bit per stage) and the
// output register. The zero vector yields 129.
module octant_vector_angle (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [15:0] dx, [31:16] dy
    input  wire logic [2*ova_pkg::DATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] angle
    output logic [ova_pkg::ANGLE_W-1:0]         m_tdata
);

    logic           fq_valid;
    logic           fq_ready;
    ova_pkg::item_t fq_item;
    logic           qb_valid;
    logic           qb_ready;
    ova_pkg::item_t qb_item;

    ova_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    ova_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    ova_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/ova_front.sv
// Input stage: takes a vector beat, forms magnitudes, quadrant and dominant axis.
`timescale 1ns / 1ps
`default_nettype none
module ova_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [2*ova_pkg::DATA_W-1:0]  s_tdata,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output ova_pkg::item_t                     q_item
);

    logic                      front_vld_reg;
    logic                      front_vld_next;
    ova_pkg::item_t            front_reg;
    ova_pkg::item_t            front_next;
    logic [ova_pkg::DATA_W-1:0] dx;
    logic [ova_pkg::DATA_W-1:0] dy;
    logic [ova_pkg::MAG_W-1:0]  mx;
    logic [ova_pkg::MAG_W-1:0]  my;
    logic                       accept;

    assign dx = s_tdata[ova_pkg::DATA_W-1:0];
    assign dy = s_tdata[2*ova_pkg::DATA_W-1:ova_pkg::DATA_W];

    assign s_tready = !front_vld_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    // -32768 maps to 0x8000, which is 32768 as an unsigned magnitude.
    assign mx = dx[ova_pkg::DATA_W-1] ? ova_pkg::MAG_W'(~dx + 1'b1) : dx;
    assign my = dy[ova_pkg::DATA_W-1] ? ova_pkg::MAG_W'(~dy + 1'b1) : dy;

    always_comb begin
        front_next           = front_reg;
        front_next.hdom      = my < mx;
        front_next.quad      = {dx[ova_pkg::DATA_W-1], dy[ova_pkg::DATA_W-1]};
        front_next.small_mag = (my < mx) ? my : mx;
        front_next.large_mag = (my < mx) ? mx : my;
        front_next.zero_vec  = (mx == '0) && (my == '0);
    end

    always_comb begin
        front_vld_next = front_vld_reg;
        if (accept) begin
            front_vld_next = 1'b1;
        end else if (q_ready) begin
            front_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= 1'b0;
        end else begin
            front_vld_reg <= front_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            front_reg <= front_next;
        end
    end

    assign q_valid = front_vld_reg;
    assign q_item  = front_reg;

endmodule
`default_nettype wire

// File: rtl/ova_queue.sv
// Short queue between the classifier and the divider pipeline.
`timescale 1ns / 1ps
`default_nettype none
module ova_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ova_pkg::item_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ova_pkg::item_t      out_item
);

    ova_pkg::item_t              mem [ova_pkg::QUEUE_DEPTH];
    logic [ova_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [ova_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [ova_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [ova_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [ova_pkg::QCNT_W-1:0]  count_reg;
    logic [ova_pkg::QCNT_W-1:0]  count_next;
    logic                        push;
    logic                        pop;

    assign in_ready  = count_reg != ova_pkg::QCNT_W'(ova_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ova_back.sv
// Divider pipeline and octant mapping: one quotient bit per stage, then the angle.
`timescale 1ns / 1ps
`default_nettype none
module ova_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire ova_pkg::item_t                q_item,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ova_pkg::ANGLE_W-1:0]        m_tdata
);

    localparam int NST = ova_pkg::DIV_STAGES;

    logic [NST-1:0]             vld_reg;
    logic [NST-1:0]             vld_next;
    logic [ova_pkg::MAG_W-1:0]  rem_reg   [NST];
    logic [ova_pkg::MAG_W-1:0]  rem_next  [NST];
    logic [ova_pkg::QUO_W-1:0]  quo_reg   [NST];
    logic [ova_pkg::QUO_W-1:0]  quo_next  [NST];
    ova_pkg::item_t             itm_reg   [NST];
    ova_pkg::item_t             itm_next  [NST];

    logic                       out_vld_reg;
    logic [ova_pkg::ANGLE_W-1:0] angle_reg;
    logic [ova_pkg::ANGLE_W-1:0] angle_next;
    logic [ova_pkg::ANGLE_W-1:0] slope;
    logic                       adv;

    logic [ova_pkg::MAG_W:0]    trial [NST];
    logic                       qbit  [NST];

    // Whole pipeline moves when the output register is free or being drained.
    assign adv     = !out_vld_reg || m_tready;
    assign q_ready = adv;

    always_comb begin
        // First step: small <= large, so the top quotient bit is set only on a tie.
        trial[0]    = {1'b0, q_item.small_mag};
        qbit[0]     = q_item.small_mag >= q_item.large_mag;
        rem_next[0] = qbit[0] ? q_item.small_mag - q_item.large_mag : q_item.small_mag;
        quo_next[0] = ova_pkg::QUO_W'(qbit[0]);
        itm_next[0] = q_item;
        vld_next[0] = q_valid;
        for (int i = 1; i < NST; i++) begin
            trial[i]    = {rem_reg[i-1], 1'b0};
            qbit[i]     = trial[i] >= {1'b0, itm_reg[i-1].large_mag};
            rem_next[i] = qbit[i]
                ? ova_pkg::MAG_W'(trial[i] - {1'b0, itm_reg[i-1].large_mag})
                : trial[i][ova_pkg::MAG_W-1:0];
            quo_next[i] = {quo_reg[i-1][ova_pkg::QUO_W-2:0], qbit[i]};
            itm_next[i] = itm_reg[i-1];
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_comb begin
        if (itm_reg[NST-1].zero_vec) begin
            slope = ova_pkg::SLOPE_ZERO_VEC;
        end else begin
            slope = ova_pkg::ANGLE_W'(quo_reg[NST-1]);
        end
        if (itm_reg[NST-1].hdom) begin
            unique case (itm_reg[NST-1].quad)
                ova_pkg::QUAD_XP_YP: angle_next = ova_pkg::ANG_RIGHT + slope;
                ova_pkg::QUAD_XP_YN: angle_next = ova_pkg::ANG_RIGHT - slope;
                ova_pkg::QUAD_XN_YP: angle_next = ova_pkg::ANG_LEFT - slope;
                default:             angle_next = ova_pkg::ANG_LEFT + slope;
            endcase
        end else begin
            unique case (itm_reg[NST-1].quad)
                ova_pkg::QUAD_XP_YP: angle_next = ova_pkg::ANG_DOWN - slope;
                ova_pkg::QUAD_XP_YN: angle_next = ova_pkg::ANG_UP + slope;
                ova_pkg::QUAD_XN_YP: angle_next = ova_pkg::ANG_DOWN + slope;
                default:             angle_next = ova_pkg::ANG_UP - slope;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NST; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                itm_reg[i] <= itm_next[i];
            end
            angle_reg <= angle_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = angle_reg;

    // Partial remainder in the first divider stage stays below the divisor for a nonzero vector.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] && !itm_reg[0].zero_vec |-> rem_reg[0] < itm_reg[0].large_mag)
        else $error("remainder not below divisor in first divider stage");

    // A ratio of at most one scaled by 32 never exceeds 32.
    a_quotient_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NST-1] && !itm_reg[NST-1].zero_vec
            |-> quo_reg[NST-1] <= ova_pkg::QUO_W'(32))
        else $error("quotient out of range");

    // A stalled output keeps the pipeline frozen.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_tready |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved while output stalled");

    // An item leaving the last divider stage lands in the output register.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[NST-1] |=> out_vld_reg)
        else $error("item dropped at output register");

endmodule
`default_nettype wire
